/* design/lpcp_pkg.sv */
// Shared types, codes and name tables for the length-prefixed command parser.
package lpcp_pkg;

  localparam int NAME_BYTES_DEF = 8;
  localparam int NUM_NAMES      = 6;
  localparam int MAX_NAME_LEN   = 8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NAME_LEN,
    PH_NAME,
    PH_VAL_LEN,
    PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    NUM_WS,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_t;

  typedef enum logic [2:0] {
    KIND_PITCH    = 3'd0,
    KIND_ROLL     = 3'd1,
    KIND_THROTTLE = 3'd2,
    KIND_YAW      = 3'd3,
    KIND_POWER    = 3'd4,
    KIND_MOTOR    = 3'd5,
    KIND_UNKNOWN  = 3'd6
  } kind_t;

  localparam logic [7:0] CHAR_MARK  = 8'h21; // '!'
  localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  localparam logic [15:0] LEN_MAX   = 16'hffff;
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;

  // Known names, zero padded to the longest one.
  localparam logic [7:0] NAME_CHARS [NUM_NAMES][MAX_NAME_LEN] = '{
    '{8'h70, 8'h69, 8'h74, 8'h63, 8'h68, 8'h00, 8'h00, 8'h00}, // pitch
    '{8'h72, 8'h6f, 8'h6c, 8'h6c, 8'h00, 8'h00, 8'h00, 8'h00}, // roll
    '{8'h74, 8'h68, 8'h72, 8'h6f, 8'h74, 8'h74, 8'h6c, 8'h65}, // throttle
    '{8'h79, 8'h61, 8'h77, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // yaw
    '{8'h70, 8'h6f, 8'h77, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00}, // power
    '{8'h6d, 8'h6f, 8'h74, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00}  // motor
  };

  localparam logic [3:0] NAME_LENS [NUM_NAMES] = '{
    4'd5, 4'd4, 4'd8, 4'd3, 4'd5, 4'd5
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

endpackage

/* design/length_prefixed_command_parser_core.sv */
// Byte-serial parser for length-prefixed commands with a registered event output.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   rx      | rx_valid, rx_stall | rx_byte
//   cmd     | cmd_valid, cmd_stall | command_kind, command_value, updated
//
// One byte a cycle while rx_stall is low: each byte is decoded combinationally
// between the parse state and the event register; the length and value
// multiply-by-ten adders set the path.
// rst (synchronous, high) returns the parser to idle and empties the event
// register. rx_stall rises only while an event waits and cmd_stall is high.
module length_prefixed_command_parser_core
  import lpcp_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               cmd_valid,
  input  logic               cmd_stall,
  output logic [2:0]         command_kind,
  output logic signed [31:0] command_value,
  output logic               updated
);

  localparam int NLW = $clog2(NAME_BYTES + 1);

  phase_t               phase, phase_next;
  logic [15:0]          length_count, length_count_next;
  logic [NLW-1:0]       name_length, name_length_next;
  logic                 name_overflow, name_overflow_next;
  logic [NUM_NAMES-1:0] match_flags, match_flags_next;
  kind_t                current_kind, current_kind_next;
  num_phase_t           number_phase, number_phase_next;
  logic                 number_negative, number_negative_next;
  logic [31:0]          number_accum, number_accum_next;

  logic        rx_fire;
  logic        emit;
  kind_t       emit_kind;
  logic [31:0] emit_value;
  logic        emit_upd;

  logic [19:0] len_times10;
  logic [15:0] len_digit;
  logic [35:0] acc_times10;
  logic [31:0] acc_digit;
  logic [31:0] value_result;
  logic        name_done;
  logic        value_done;
  kind_t       name_kind;

  assign rx_stall = cmd_valid && cmd_stall;
  assign rx_fire  = rx_valid && !rx_stall;

  // Saturating decimal accumulators.
  always_comb begin
    len_times10 = {1'b0, length_count, 3'b000} + {3'b000, length_count, 1'b0}
                + {12'd0, rx_byte - CHAR_ZERO};
    len_digit   = (len_times10 > {4'd0, LEN_MAX}) ? LEN_MAX : len_times10[15:0];
    acc_times10 = {1'b0, number_accum, 3'b000} + {3'b000, number_accum, 1'b0}
                + {28'd0, rx_byte - CHAR_ZERO};
    acc_digit   = (acc_times10 > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc_times10[31:0];
  end

  // Datapath next values.
  always_comb begin
    length_count_next    = length_count;
    name_length_next     = name_length;
    name_overflow_next   = name_overflow;
    match_flags_next     = match_flags;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    number_accum_next    = number_accum;
    name_done            = 1'b0;
    value_done           = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (rx_byte == CHAR_MARK) length_count_next = '0;
      end
      PH_NAME_LEN, PH_VAL_LEN: begin
        if (is_digit(rx_byte)) begin
          length_count_next = len_digit;
        end else begin
          name_length_next     = '0;
          name_overflow_next   = 1'b0;
          match_flags_next     = '1;
          number_phase_next    = NUM_WS;
          number_negative_next = 1'b0;
          number_accum_next    = '0;
        end
      end
      PH_NAME: begin
        if (name_length < NLW'(NAME_BYTES)) begin
          for (int k = 0; k < NUM_NAMES; k++) begin
            match_flags_next[k] = match_flags[k]
              && (name_length < NLW'(NAME_LENS[k]))
              && (rx_byte == NAME_CHARS[k][name_length[2:0]]);
          end
          name_length_next = name_length + NLW'(1);
        end else begin
          name_overflow_next = 1'b1;
        end
        length_count_next = length_count - 16'd1;
        name_done         = (length_count_next == '0);
      end
      PH_VALUE: begin
        if (number_phase == NUM_WS) begin
          if (!is_space(rx_byte)) begin
            if (rx_byte == CHAR_MINUS) begin
              number_phase_next    = NUM_DIGITS;
              number_negative_next = 1'b1;
            end else if (rx_byte == CHAR_PLUS) begin
              number_phase_next = NUM_DIGITS;
            end else if (is_digit(rx_byte)) begin
              number_phase_next = NUM_DIGITS;
              number_accum_next = acc_digit;
            end else begin
              number_phase_next = NUM_DONE;
            end
          end
        end else if (number_phase == NUM_DIGITS) begin
          if (is_digit(rx_byte)) number_accum_next = acc_digit;
          else                   number_phase_next = NUM_DONE;
        end
        length_count_next = length_count - 16'd1;
        value_done        = (length_count_next == '0);
      end
      default: length_count_next = '0;
    endcase
  end

  // Name match on the flags including the final byte.
  always_comb begin
    name_kind = KIND_UNKNOWN;
    for (int k = NUM_NAMES - 1; k >= 0; k--) begin
      if (!name_overflow_next && match_flags_next[k]
          && (name_length_next == NLW'(NAME_LENS[k])))
        name_kind = kind_t'(3'(k));
    end
  end

  always_comb begin
    if (number_negative_next)
      value_result = 32'd0 - number_accum_next;
    else if (number_accum_next >= MAG_LIMIT)
      value_result = POS_MAX;
    else
      value_result = number_accum_next;
  end

  // Event decode.
  always_comb begin
    emit              = 1'b0;
    emit_kind         = KIND_UNKNOWN;
    emit_value        = '0;
    emit_upd          = 1'b0;
    current_kind_next = current_kind;
    unique case (phase)
      PH_NAME_LEN: begin
        if (!is_digit(rx_byte) && length_count == '0) emit = 1'b1;
      end
      PH_NAME: begin
        if (name_done) begin
          current_kind_next = name_kind;
          emit              = (name_kind == KIND_UNKNOWN);
        end
      end
      PH_VAL_LEN: begin
        if (!is_digit(rx_byte) && length_count == '0) begin
          emit      = 1'b1;
          emit_kind = current_kind;
          // empty value: throttle and yaw become zero, others report no update
          emit_upd  = (current_kind == KIND_THROTTLE) || (current_kind == KIND_YAW);
        end
      end
      PH_VALUE: begin
        if (value_done) begin
          emit      = 1'b1;
          emit_kind = current_kind;
          if (current_kind == KIND_POWER || current_kind == KIND_MOTOR ||
              current_kind == KIND_UNKNOWN) begin
            emit_upd = 1'b0;
          end else begin
            emit_upd   = 1'b1;
            emit_value = value_result;
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // Phase sequencing.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:     if (rx_byte == CHAR_MARK) phase_next = PH_NAME_LEN;
      PH_NAME_LEN: if (!is_digit(rx_byte)) phase_next = PH_NAME;
      PH_NAME:     if (name_done) phase_next = PH_VAL_LEN;
      PH_VAL_LEN:  if (!is_digit(rx_byte)) phase_next = PH_VALUE;
      PH_VALUE:    phase_next = PH_VALUE;
      default:     phase_next = PH_IDLE;
    endcase
    if (emit) phase_next = PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      length_count    <= '0;
      name_length     <= '0;
      name_overflow   <= 1'b0;
      match_flags     <= '1;
      current_kind    <= KIND_PITCH;
      number_phase    <= NUM_WS;
      number_negative <= 1'b0;
      number_accum    <= '0;
      cmd_valid       <= 1'b0;
    end else begin
      if (rx_fire) begin
        phase           <= phase_next;
        length_count    <= emit ? 16'd0 : length_count_next;
        name_length     <= name_length_next;
        name_overflow   <= name_overflow_next;
        match_flags     <= match_flags_next;
        current_kind    <= current_kind_next;
        number_phase    <= number_phase_next;
        number_negative <= number_negative_next;
        number_accum    <= number_accum_next;
      end
      if (rx_fire && emit) cmd_valid <= 1'b1;
      else if (!cmd_stall) cmd_valid <= 1'b0;
    end
  end

  // Event word register.
  always_ff @(posedge clk) begin
    if (rx_fire && emit) begin
      command_kind  <= emit_kind;
      command_value <= emit_value;
      updated       <= emit_upd;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the length-prefixed command parser core.
import lpcp_pkg::*;

typedef struct {
  kind_t       kind;
  logic [31:0] value;
  logic        upd;
} cmd_event_t;

// Tracks the parser state byte by byte and checks the events it emits.
class cmd_scoreboard;
  string known_names[NUM_NAMES] = '{"pitch", "roll", "throttle", "yaw", "power", "motor"};

  phase_t      phase;
  num_phase_t  num_state;
  logic [15:0] len_cnt;
  logic [7:0]  name_buf[NAME_BYTES_DEF];
  int          name_len;
  bit          name_ovf;
  kind_t       cur_kind;
  bit          negative;
  logic [31:0] magnitude;
  cmd_event_t  expected_events[$];
  int          errors;

  function new();
    phase     = PH_IDLE;
    num_state = NUM_WS;
    len_cnt   = '0;
    name_len  = 0;
    name_ovf  = 1'b0;
    cur_kind  = KIND_PITCH;
    negative  = 1'b0;
    magnitude = '0;
    errors    = 0;
  endfunction

  function bit is_dec(logic [7:0] b);
    return b >= CHAR_ZERO && b <= CHAR_NINE;
  endfunction

  // Length prefix digits saturate at 16 bits.
  function void add_len_digit(logic [7:0] b);
    int unsigned v;
    v = int'(len_cnt) * 10 + int'(b - CHAR_ZERO);
    len_cnt = (v > 32'hffff) ? LEN_MAX : v[15:0];
  endfunction

  function void post_event(kind_t k, logic [31:0] v, logic u);
    cmd_event_t e;
    e.kind  = k;
    e.value = v;
    e.upd   = u;
    expected_events = {expected_events, e};
    phase   = PH_IDLE;
    len_cnt = '0;
  endfunction

  function void close_value();
    logic [31:0] v;
    if (cur_kind == KIND_POWER || cur_kind == KIND_MOTOR) begin
      post_event(cur_kind, '0, 1'b0);
    end else begin
      if (negative) v = -magnitude;
      else if (magnitude >= MAG_LIMIT) v = POS_MAX;
      else v = magnitude;
      post_event(cur_kind, v, 1'b1);
    end
  endfunction

  function void note_byte(logic [7:0] b);
    logic [63:0] wide;
    kind_t       k;
    bit          hit;
    bit          skip;
    case (phase)
      PH_IDLE: begin
        if (b == CHAR_MARK) begin
          phase   = PH_NAME_LEN;
          len_cnt = '0;
        end
      end
      PH_NAME_LEN: begin
        if (is_dec(b)) begin
          add_len_digit(b);
        end else begin
          name_len = 0;
          name_ovf = 1'b0;
          if (len_cnt == 0) post_event(KIND_UNKNOWN, '0, 1'b0);
          else phase = PH_NAME;
        end
      end
      PH_NAME: begin
        if (name_len < NAME_BYTES_DEF) begin
          name_buf[name_len] = b;
          name_len++;
        end else begin
          name_ovf = 1'b1;
        end
        len_cnt--;
        if (len_cnt == 0) begin
          k = KIND_UNKNOWN;
          for (int i = 0; i < NUM_NAMES; i++) begin
            hit = !name_ovf && name_len == known_names[i].len();
            for (int j = 0; j < name_len && hit; j++) hit = name_buf[j] == known_names[i][j];
            if (hit && k == KIND_UNKNOWN) k = kind_t'(i);
          end
          cur_kind = k;
          if (k == KIND_UNKNOWN) post_event(KIND_UNKNOWN, '0, 1'b0);
          else phase = PH_VAL_LEN;
        end
      end
      PH_VAL_LEN: begin
        if (is_dec(b)) begin
          add_len_digit(b);
        end else begin
          num_state = NUM_WS;
          negative  = 1'b0;
          magnitude = '0;
          if (len_cnt != 0) phase = PH_VALUE;
          // empty pitch/roll value leaves the setpoint alone
          else if (cur_kind == KIND_PITCH || cur_kind == KIND_ROLL) post_event(cur_kind, '0, 1'b0);
          else close_value();
        end
      end
      PH_VALUE: begin
        skip = 1'b0;
        if (num_state == NUM_WS) begin
          if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)) begin
            skip = 1'b1;
          end else begin
            num_state = NUM_DIGITS;
            negative  = (b == CHAR_MINUS);
            skip      = (b == CHAR_MINUS || b == CHAR_PLUS);
          end
        end
        if (!skip && num_state == NUM_DIGITS) begin
          if (is_dec(b)) begin
            wide = 64'(magnitude) * 10 + 64'(b - CHAR_ZERO);
            magnitude = (wide > 64'(MAG_LIMIT)) ? MAG_LIMIT : wide[31:0];
          end else begin
            num_state = NUM_DONE;
          end
        end
        len_cnt--;
        if (len_cnt == 0) close_value();
      end
      default: begin
        phase   = PH_IDLE;
        len_cnt = '0;
      end
    endcase
  endfunction

  function void check_event(logic [2:0] kind, logic [31:0] value, logic upd);
    cmd_event_t e;
    if (expected_events.size() == 0) begin
      $error("unexpected event: kind %0d value %0d updated %0d", kind, $signed(value), upd);
      errors++;
      return;
    end
    e = expected_events.pop_front();
    if (kind !== e.kind) begin
      $error("command_kind: expected %0d, got %0d", e.kind, kind);
      errors++;
    end
    if (value !== e.value) begin
      $error("command_value: expected %0d, got %0d", $signed(e.value), $signed(value));
      errors++;
    end
    if (upd !== e.upd) begin
      $error("updated: expected %0d, got %0d", e.upd, upd);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic               clk;
  logic               rst;
  logic               rx_valid;
  logic               rx_stall;
  logic [7:0]         rx_byte;
  logic               cmd_valid;
  logic               cmd_stall;
  logic [2:0]         command_kind;
  logic signed [31:0] command_value;
  logic               updated;

  cmd_scoreboard sb;
  bit            quiet;
  int            cmd_bytes;

  length_prefixed_command_parser_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command_kind (command_kind),
    .command_value(command_value),
    .updated      (updated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("length_prefixed_command_parser_core regression: fail");
    $finish;
  end

  // Event from earlier bytes is checked before this edge's byte is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.check_event(command_kind, command_value, updated);
      if (rx_valid && !rx_stall) sb.note_byte(rx_byte);
    end
  end

  // Event sink back-pressure in bursts.
  initial begin
    cmd_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && !rst && $urandom_range(0, 9) == 0) begin
        cmd_stall <= 1'b1;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        cmd_stall <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic push_text(ref logic [7:0] q[$], input string s);
    foreach (s[i]) q = {q, s[i]};
  endtask

  function automatic logic [7:0] length_end();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) return 8'h3a;
    do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
    return b;
  endfunction

  task automatic random_command();
    logic [7:0] q[$];
    logic [7:0] name[$];
    logic [7:0] val[$];
    logic [7:0] b;
    int         shape;
    int         k;
    int         declared;
    int         noise;
    bit         known;
    noise = 0;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b != CHAR_MARK) begin
          q = {q, b};
          noise++;
        end
      end
    end
    q = {q, CHAR_MARK};
    shape = $urandom_range(0, 15);
    known = shape <= 10 || shape == 15;
    k = $urandom_range(0, NUM_NAMES - 1);
    if (known || shape == 14) push_text(name, sb.known_names[k]);
    if (shape == 14) name[$urandom_range(0, name.size() - 1)] ^= 8'h20;  // near miss
    if (shape == 12) repeat ($urandom_range(9, 14)) name = {name, 8'($urandom_range(8'h61, 8'h7a))};
    if (shape == 13) repeat ($urandom_range(1, 8)) name = {name, 8'($urandom_range(0, 255))};
    declared = name.size();
    // declared length off by one: a broken frame
    if (shape == 15) declared += ($urandom_range(0, 1) != 0) ? 1 : -1;
    if ($urandom_range(0, 7) == 0) q = {q, CHAR_ZERO};
    push_text(q, $sformatf("%0d", declared));
    q = {q, length_end()};
    q = {q, name};
    if (known) begin
      if ($urandom_range(0, 9) != 0) begin
        repeat ($urandom_range(0, 2)) begin
          b = 8'($urandom_range(8, 13));
          val = {val, ((b == 8'h08) ? CHAR_SPACE : b)};
        end
        case ($urandom_range(0, 3))
          0: val = {val, CHAR_MINUS};
          1: val = {val, CHAR_PLUS};
          default: ;
        endcase
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5))
          val = {val, 8'(CHAR_ZERO + $urandom_range(0, 9))};
        repeat ($urandom_range(0, 2)) val = {val, 8'($urandom_range(0, 255))};
      end
      if ($urandom_range(0, 15) == 0) q = {q, CHAR_ZERO};
      push_text(q, $sformatf("%0d", val.size()));
      q = {q, length_end()};
      q = {q, val};
    end
    foreach (q[i]) send_byte(q[i]);
    cmd_bytes += q.size() - noise;
  endtask

  initial begin
    logic [7:0] q[$];
    sb        = new();
    rst       = 1'b1;
    rx_valid  = 1'b0;
    rx_byte   = '0;
    quiet     = 1'b0;
    cmd_bytes = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("!5:pitch3:-42");
    send_text("!0:");
    send_text("!4:roll0:");
    send_text("!3:yaw11:99999999999");

    while (cmd_bytes < 1100) begin
      if (cmd_bytes > 950) quiet = 1'b1;
      random_command();
    end

    // value length 65537 saturates at 65535, so the parser is still inside the
    // value when the run ends; a wrapped length would end it after one byte
    push_text(q, "!3:yaw65537: -12");
    repeat (16) q = {q, 8'($urandom_range(0, 255))};
    foreach (q[i]) send_byte(q[i]);
    rx_valid <= 1'b0;

    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("length_prefixed_command_parser_core regression: pass");
    end else begin
      $display("length_prefixed_command_parser_core regression: fail");
    end
    $finish;
  end
endmodule
